// ----- sv/sapa_pkg.sv -----
package sapa_pkg;

	localparam int AREA_BITS      = 40;
	localparam int PERIM_BITS     = 20;
	localparam int SUM_AREA_BITS  = 48;
	localparam int SUM_PERIM_BITS = 32;
	localparam int PI_BITS        = 18;
	localparam int ROUND_SHIFT    = 16;

	localparam logic [PI_BITS-1:0]     PI_Q16    = 18'd205887;
	localparam logic [ROUND_SHIFT-1:0] RND_HALF  = 16'h8000;
	localparam logic [AREA_BITS-1:0]   AREA_MAX  = '1;
	localparam logic [PERIM_BITS-1:0]  PERIM_MAX = '1;

	localparam logic [1:0] OP_CIRCLE = 2'd0;
	localparam logic [1:0] OP_RECT   = 2'd1;
	localparam logic [1:0] OP_TRI    = 2'd2;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef enum logic [2:0] {
		MX_A,
		MX_S,
		MX_FQ,
		MX_T1LO,
		MX_T1HI
	} mx_sel_t;

	typedef enum logic [2:0] {
		MY_A,
		MY_B,
		MY_FP,
		MY_FR,
		MY_PI,
		MY_T2LO,
		MY_T2HI
	} my_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_CLR,
		ACC_ADD
	} acc_op_t;

	typedef enum logic [1:0] {
		SH_0,
		SH_1,
		SH_W,
		SH_2W
	} sh_sel_t;

	typedef enum logic [1:0] {
		AR_NONE,
		AR_ROUND,
		AR_PROD,
		AR_ROOT
	} area_src_t;

	typedef struct packed {
		mx_sel_t   mul_x;
		my_sel_t   mul_y;
		logic      t1_wr;
		logic      t2_wr;
		acc_op_t   acc_op;
		sh_sel_t   sh;
		area_src_t area_wr;
		logic      perim_rnd;
		logic      sq_step;
		logic      last;
	} ctrl_t;

	localparam ctrl_t CTRL_NOP = '{
		mul_x: MX_A, mul_y: MY_A, t1_wr: 1'b0, t2_wr: 1'b0, acc_op: ACC_HOLD,
		sh: SH_0, area_wr: AR_NONE, perim_rnd: 1'b0, sq_step: 1'b0, last: 1'b0
	};

	// per-shape step program for the shared multiply/accumulate datapath
	function automatic ctrl_t ucode(input logic [1:0] kind, input logic [2:0] step);
		ctrl_t c;
		c = CTRL_NOP;
		case (kind)
			OP_CIRCLE: begin
				case (step)
					3'd0: begin
						c.mul_x  = MX_A;
						c.mul_y  = MY_A;
						c.acc_op = ACC_CLR;
					end
					3'd1: begin
						c.t1_wr = 1'b1;
						c.mul_x = MX_A;
						c.mul_y = MY_PI;
					end
					3'd2: begin
						c.acc_op = ACC_ADD;
						c.sh     = SH_1;
					end
					3'd3: begin
						c.perim_rnd = 1'b1;
						c.acc_op    = ACC_CLR;
						c.mul_x     = MX_T1LO;
						c.mul_y     = MY_PI;
					end
					3'd4: begin
						c.mul_x  = MX_T1HI;
						c.mul_y  = MY_PI;
						c.acc_op = ACC_ADD;
						c.sh     = SH_0;
					end
					3'd5: begin
						c.acc_op = ACC_ADD;
						c.sh     = SH_W;
					end
					3'd6: begin
						c.area_wr = AR_ROUND;
						c.last    = 1'b1;
					end
					default: c = CTRL_NOP;
				endcase
			end
			OP_RECT: begin
				case (step)
					3'd0: begin
						c.mul_x = MX_A;
						c.mul_y = MY_B;
					end
					3'd1: begin
						c.area_wr = AR_PROD;
						c.last    = 1'b1;
					end
					default: c = CTRL_NOP;
				endcase
			end
			OP_TRI: begin
				case (step)
					3'd0: begin
						c.mul_x = MX_S;
						c.mul_y = MY_FP;
					end
					3'd1: begin
						c.t1_wr = 1'b1;
						c.mul_x = MX_FQ;
						c.mul_y = MY_FR;
					end
					3'd2: begin
						c.t2_wr  = 1'b1;
						c.acc_op = ACC_CLR;
					end
					3'd3: begin
						c.mul_x = MX_T1LO;
						c.mul_y = MY_T2LO;
					end
					3'd4: begin
						c.mul_x  = MX_T1LO;
						c.mul_y  = MY_T2HI;
						c.acc_op = ACC_ADD;
						c.sh     = SH_0;
					end
					3'd5: begin
						c.mul_x  = MX_T1HI;
						c.mul_y  = MY_T2LO;
						c.acc_op = ACC_ADD;
						c.sh     = SH_W;
					end
					3'd6: begin
						c.mul_x  = MX_T1HI;
						c.mul_y  = MY_T2HI;
						c.acc_op = ACC_ADD;
						c.sh     = SH_W;
					end
					3'd7: begin
						c.acc_op = ACC_ADD;
						c.sh     = SH_2W;
						c.last   = 1'b1;
					end
					default: c = CTRL_NOP;
				endcase
			end
			default: c = CTRL_NOP;
		endcase
		return c;
	endfunction

endpackage

// ----- sv/sapa_dp.sv -----
module sapa_dp #(
	parameter int DIM_BITS = 16
) (
	input  logic                           clk,
	input  logic                           start,
	input  logic [1:0]                     opcode,
	input  logic [DIM_BITS-1:0]            dim_a,
	input  logic [DIM_BITS-1:0]            dim_b,
	input  logic [DIM_BITS-1:0]            dim_c,
	input  sapa_pkg::ctrl_t                ctl,
	output logic                           ok,
	output logic [sapa_pkg::AREA_BITS-1:0]  area,
	output logic [sapa_pkg::PERIM_BITS-1:0] perim
);
	import sapa_pkg::*;

	localparam int M    = DIM_BITS + 2;
	localparam int W    = (M > PI_BITS) ? M : PI_BITS;
	localparam int PW   = 2 * W;
	localparam int AW   = 4 * W;
	localparam int NR   = 2 * W;
	localparam int REMW = NR + 2;
	localparam int RNW  = AW + 1 - ROUND_SHIFT;
	localparam int PXW  = (M > PERIM_BITS) ? M : PERIM_BITS;
	localparam int AXW  = (PW > AREA_BITS) ? PW : AREA_BITS;

	logic [M-1:0]    ea, eb, ec, ab, bc, ca, s_ld, fp_ld, fq_ld, fr_ld, perim_ld;
	logic            ok_ld;
	logic [PXW-1:0]  perim_ext;
	logic [PERIM_BITS-1:0] perim_ld_sat;

	logic [M-1:0]    a_q, b_q, s_q, fp_q, fq_q, fr_q;
	logic            ok_q;
	logic [PW-1:0]   prod_q, t1_q, t2_q;
	logic [AW-1:0]   acc_q;
	logic [REMW-1:0] rem_q;
	logic [NR-1:0]   root_q;
	logic [AREA_BITS-1:0]  area_q;
	logic [PERIM_BITS-1:0] perim_q;

	logic [W-1:0]    mx, my;
	logic [AW-1:0]   pshift;
	logic [REMW-1:0] rem_pre, trial;
	logic [AW:0]     add_a, add_b, add_sum;
	logic            add_cin, ge, rnd_op;
	logic [RNW-1:0]  rnd;
	logic [AXW-1:0]  prod_ext, root_ext;

	// item checks and triangle factors
	always_comb begin
		ea    = M'(dim_a);
		eb    = M'(dim_b);
		ec    = M'(dim_c);
		ab    = ea + eb;
		bc    = eb + ec;
		ca    = ec + ea;
		s_ld  = ab + ec;
		fp_ld = bc - ea;
		fq_ld = ca - eb;
		fr_ld = ab - ec;
		case (opcode)
			OP_CIRCLE: ok_ld = (dim_a != '0);
			OP_RECT:   ok_ld = (dim_a != '0) && (dim_b != '0);
			OP_TRI:    ok_ld = (dim_a != '0) && (dim_b != '0) && (dim_c != '0) &&
			                   (ab > ec) && (bc > ea) && (ca > eb);
			default:   ok_ld = 1'b0;
		endcase
		perim_ld     = (opcode == OP_RECT) ? {ab[M-2:0], 1'b0} : s_ld;
		perim_ext    = PXW'(perim_ld);
		perim_ld_sat = (perim_ext > PXW'(PERIM_MAX)) ? PERIM_MAX : perim_ext[PERIM_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= ea;
			b_q  <= eb;
			s_q  <= s_ld;
			fp_q <= fp_ld;
			fq_q <= fq_ld;
			fr_q <= fr_ld;
			ok_q <= ok_ld;
		end
	end

	// shared multiplier
	always_comb begin
		case (ctl.mul_x)
			MX_A:    mx = W'(a_q);
			MX_S:    mx = W'(s_q);
			MX_FQ:   mx = W'(fq_q);
			MX_T1LO: mx = t1_q[W-1:0];
			MX_T1HI: mx = t1_q[PW-1:W];
			default: mx = '0;
		endcase
		case (ctl.mul_y)
			MY_A:    my = W'(a_q);
			MY_B:    my = W'(b_q);
			MY_FP:   my = W'(fp_q);
			MY_FR:   my = W'(fr_q);
			MY_PI:   my = W'(PI_Q16);
			MY_T2LO: my = t2_q[W-1:0];
			MY_T2HI: my = t2_q[PW-1:W];
			default: my = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mx * my;
		if (ctl.t1_wr) begin
			t1_q <= prod_q;
		end
		if (ctl.t2_wr) begin
			t2_q <= prod_q;
		end
	end

	// shared adder: accumulate, round, or square root trial subtract
	always_comb begin
		case (ctl.sh)
			SH_0:    pshift = AW'(prod_q);
			SH_1:    pshift = AW'(prod_q) << 1;
			SH_W:    pshift = AW'(prod_q) << W;
			SH_2W:   pshift = AW'(prod_q) << (2 * W);
			default: pshift = '0;
		endcase
		rem_pre = {rem_q[REMW-3:0], acc_q[AW-1:AW-2]};
		trial   = {root_q, 2'b01};
		rnd_op  = (ctl.area_wr == AR_ROUND) || ctl.perim_rnd;
		if (ctl.sq_step) begin
			add_a   = (AW+1)'(rem_pre);
			add_b   = ~((AW+1)'(trial));
			add_cin = 1'b1;
		end else if (rnd_op) begin
			add_a   = {1'b0, acc_q};
			add_b   = (AW+1)'(RND_HALF);
			add_cin = 1'b0;
		end else begin
			add_a   = {1'b0, acc_q};
			add_b   = {1'b0, pshift};
			add_cin = 1'b0;
		end
		add_sum  = add_a + add_b + (AW+1)'(add_cin);
		ge       = ~add_sum[AW];
		rnd      = add_sum[AW:ROUND_SHIFT];
		prod_ext = AXW'(prod_q);
		root_ext = AXW'(root_q >> 2);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			root_q <= '0;
		end else if (ctl.sq_step) begin
			acc_q  <= acc_q << 2;
			rem_q  <= ge ? add_sum[REMW-1:0] : rem_pre;
			root_q <= {root_q[NR-2:0], ge};
		end else begin
			case (ctl.acc_op)
				ACC_CLR:  acc_q <= '0;
				ACC_ADD:  acc_q <= add_sum[AW-1:0];
				ACC_HOLD: acc_q <= acc_q;
				default:  acc_q <= acc_q;
			endcase
		end
	end

	// shape results, saturated
	always_ff @(posedge clk) begin
		if (start) begin
			perim_q <= perim_ld_sat;
		end else if (ctl.perim_rnd) begin
			perim_q <= (|rnd[RNW-1:PERIM_BITS]) ? PERIM_MAX : rnd[PERIM_BITS-1:0];
		end
		case (ctl.area_wr)
			AR_ROUND: area_q <= (|rnd[RNW-1:AREA_BITS]) ? AREA_MAX : rnd[AREA_BITS-1:0];
			AR_PROD:  area_q <= (prod_ext > AXW'(AREA_MAX)) ? AREA_MAX
			                                                : prod_ext[AREA_BITS-1:0];
			AR_ROOT:  area_q <= (root_ext > AXW'(AREA_MAX)) ? AREA_MAX
			                                                : root_ext[AREA_BITS-1:0];
			default:  area_q <= area_q;
		endcase
	end

	assign ok    = ok_q;
	assign area  = area_q;
	assign perim = perim_q;

endmodule

// ----- sv/sapa_ctrl.sv -----
module sapa_ctrl #(
	parameter int DIM_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      opcode,
	input  logic            ok,
	input  logic            retire,
	output logic            idle,
	output logic            done,
	output sapa_pkg::ctrl_t ctl
);
	import sapa_pkg::*;

	localparam int M  = DIM_BITS + 2;
	localparam int W  = (M > PI_BITS) ? M : PI_BITS;
	localparam int NR = 2 * W;
	localparam int CW = $clog2(NR);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RUN  = 5'b00010,
		ST_SQRT = 5'b00100,
		ST_ROOT = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [1:0]      kind_q;

	always_comb begin
		ctl = CTRL_NOP;
		case (state_q)
			ST_RUN:  ctl = ucode(kind_q, cnt_q[2:0]);
			ST_SQRT: ctl.sq_step = 1'b1;
			ST_ROOT: ctl.area_wr = AR_ROOT;
			default: ctl = CTRL_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			kind_q  <= OP_CIRCLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
						kind_q  <= opcode;
					end
				end
				ST_RUN: begin
					// rejected shapes skip straight to the result
					if ((cnt_q == '0) && !ok) begin
						state_q <= ST_DONE;
					end else if (ctl.last) begin
						state_q <= (kind_q == OP_TRI) ? ST_SQRT : ST_DONE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_SQRT: begin
					if (cnt_q == CW'(NR - 1)) begin
						state_q <= ST_ROOT;
					end
					cnt_q <= cnt_q + CW'(1);
				end
				ST_ROOT: state_q <= ST_DONE;
				ST_DONE: begin
					if (retire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign idle = (state_q == ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

// ----- sv/shape_area_perimeter_accumulator_core.sv -----
// an item steps through the states run, then sqrt and root for a triangle, then done;
// a rejected shape goes from run straight to done; W = max(DIM_BITS + 2, 18) below
// the triangle root is taken one bit per cycle on the shared adder, after six partial
// products on the shared W x W multiplier; one item is in flight, the next is taken the
// cycle after the result moves to the output register, once it is free or out_ready high
// arst_n clears the sequencer, the output valid and both running totals to zero
module shape_area_perimeter_accumulator_core #(
	parameter int DIM_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          opcode,
	input  logic [DIM_BITS-1:0]                 dim_a,
	input  logic [DIM_BITS-1:0]                 dim_b,
	input  logic [DIM_BITS-1:0]                 dim_c,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                status,
	output logic [sapa_pkg::AREA_BITS-1:0]      shape_area,
	output logic [sapa_pkg::PERIM_BITS-1:0]     shape_perimeter,
	output logic [sapa_pkg::SUM_AREA_BITS-1:0]  sum_area,
	output logic [sapa_pkg::SUM_PERIM_BITS-1:0] sum_perimeter
);
	import sapa_pkg::*;

	logic            start, idle, done, retire, ok;
	ctrl_t           ctl;
	logic [AREA_BITS-1:0]  area;
	logic [PERIM_BITS-1:0] perim;

	logic                      out_valid_q, status_q;
	logic [AREA_BITS-1:0]      shape_area_q;
	logic [PERIM_BITS-1:0]     shape_perim_q;
	logic [SUM_AREA_BITS-1:0]  area_total_q;
	logic [SUM_PERIM_BITS-1:0] perim_total_q;
	logic [SUM_AREA_BITS:0]    area_add;
	logic [SUM_PERIM_BITS:0]   perim_add;

	assign in_ready = idle;
	assign start    = in_valid & idle;
	assign retire   = done & (~out_valid_q | out_ready);

	sapa_ctrl #(.DIM_BITS(DIM_BITS)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.ok     (ok),
		.retire (retire),
		.idle   (idle),
		.done   (done),
		.ctl    (ctl)
	);

	sapa_dp #(.DIM_BITS(DIM_BITS)) u_dp (
		.clk    (clk),
		.start  (start),
		.opcode (opcode),
		.dim_a  (dim_a),
		.dim_b  (dim_b),
		.dim_c  (dim_c),
		.ctl    (ctl),
		.ok     (ok),
		.area   (area),
		.perim  (perim)
	);

	assign area_add  = {1'b0, area_total_q} + (SUM_AREA_BITS+1)'(area);
	assign perim_add = {1'b0, perim_total_q} + (SUM_PERIM_BITS+1)'(perim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			area_total_q  <= '0;
			perim_total_q <= '0;
		end else begin
			if (retire) begin
				out_valid_q <= 1'b1;
				if (ok) begin
					area_total_q  <= area_add[SUM_AREA_BITS] ? '1
					                                         : area_add[SUM_AREA_BITS-1:0];
					perim_total_q <= perim_add[SUM_PERIM_BITS] ? '1
					                                           : perim_add[SUM_PERIM_BITS-1:0];
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			status_q      <= ok ? STATUS_OK : STATUS_REJECT;
			shape_area_q  <= ok ? area : '0;
			shape_perim_q <= ok ? perim : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign shape_area      = shape_area_q;
	assign shape_perimeter = shape_perim_q;
	assign sum_area        = area_total_q;
	assign sum_perimeter   = perim_total_q;

endmodule
